/* rtl/tfbm_pkg.sv */
// ----------------------------------------------------------------------------
// tfbm_pkg
// Shared types and constants of the TCP flow byte meter: flow key layout,
// result status codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tfbm_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // Configuration register map (byte addresses, 64-bit registers).
   localparam int unsigned CSR_ADDR_W          = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_INTERVAL = 4'h0;
   localparam logic [63:0] INTERVAL_RESET      = 64'd1000000000;

   typedef struct packed {
      logic [31:0] proc_id;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [31:0] dst_addr;
      logic [15:0] dst_port;
   } flow_key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_EVAL,
      ST_MISS
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new item and restart the key scan
      logic scan_en;     // issue key reads while the scan runs
      logic latch_hit;   // remember the index of the matching entry
      logic emit_drop;   // finish an ignored or rejected item
      logic emit_hit;    // finish a known flow: report, restamp, accumulate
      logic emit_miss;   // finish a new flow: report and insert
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drop;        // item needs no table access
      logic hit;         // key at the compare stage matches the item
      logic scan_done;   // every stored key has been compared
      logic out_free;    // the result register can take a new item
   } ctl_sts_type;

endpackage

/* rtl/tfbm_ctrl.sv */
// ----------------------------------------------------------------------------
// tfbm_ctrl
// Sequencer of the flow meter. Accepts one item at a time, runs the key
// scan and picks the way the item is finished.
// ----------------------------------------------------------------------------
module tfbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tfbm_pkg::ctl_sts_type sts,
   output tfbm_pkg::ctl_cmd_type cmd
);

   tfbm_pkg::state_type state_ff;
   tfbm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfbm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tfbm_pkg::ST_SCAN;
            end
         end
         tfbm_pkg::ST_SCAN: begin
            if (sts.drop) begin
               if (sts.out_free) begin
                  state_in = tfbm_pkg::ST_IDLE;
               end
            end else if (sts.hit) begin
               state_in = tfbm_pkg::ST_FETCH;
            end else if (sts.scan_done) begin
               state_in = tfbm_pkg::ST_MISS;
            end
         end
         tfbm_pkg::ST_FETCH: begin
            state_in = tfbm_pkg::ST_EVAL;
         end
         tfbm_pkg::ST_EVAL, tfbm_pkg::ST_MISS: begin
            if (sts.out_free) begin
               state_in = tfbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfbm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tfbm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tfbm_pkg::ST_SCAN: begin
            cmd.scan_en   = 1'b1;
            cmd.emit_drop = sts.drop && sts.out_free;
            cmd.latch_hit = !sts.drop && sts.hit;
         end
         tfbm_pkg::ST_FETCH: begin
            cmd = '0;
         end
         tfbm_pkg::ST_EVAL: begin
            cmd.emit_hit = sts.out_free;
         end
         tfbm_pkg::ST_MISS: begin
            cmd.emit_miss = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/tfbm_datapath.sv */
// ----------------------------------------------------------------------------
// tfbm_datapath
// Item register, flow table memories, key scan pipeline, export decision
// and result register of the flow meter.
// ----------------------------------------------------------------------------
module tfbm_datapath #(
   parameter int unsigned FLOW_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tfbm_pkg::ctl_cmd_type  cmd,
   output tfbm_pkg::ctl_sts_type  sts,
   input  logic [63:0]            export_interval,
   input  logic                   req_is_transmit,
   input  logic                   req_is_ipv4,
   input  tfbm_pkg::flow_key_type req_key,
   input  logic signed [31:0]     req_byte_count,
   input  logic [63:0]            req_now_ns,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_export_valid,
   output tfbm_pkg::flow_key_type rsp_key,
   output logic [63:0]            rsp_tx_total,
   output logic [63:0]            rsp_rx_total
);

   localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(FLOW_ENTRIES + 1);

   // Item register.
   logic                   itm_tx_ff;
   logic                   itm_v4_ff;
   tfbm_pkg::flow_key_type itm_key_ff;
   logic signed [31:0]     itm_cnt_ff;
   logic [63:0]            itm_now_ff;

   // Flow table. Entries are filled from the bottom and never freed, so the
   // valid entries are always those below the fill count.
   tfbm_pkg::flow_key_type key_mem  [FLOW_ENTRIES];
   logic [63:0]            time_mem [FLOW_ENTRIES];
   logic [63:0]            tx_mem   [FLOW_ENTRIES];
   logic [63:0]            rx_mem   [FLOW_ENTRIES];

   logic [CNT_W-1:0]       fill_ff;
   logic [CNT_W-1:0]       scan_idx_ff;
   logic                   cmp_vld_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   tfbm_pkg::flow_key_type key_rd_ff;
   logic [63:0]            time_rd_ff;
   logic [63:0]            tx_rd_ff;
   logic [63:0]            rx_rd_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [1:0]             rsp_status_ff;
   logic                   rsp_export_ff;
   tfbm_pkg::flow_key_type rsp_key_ff;
   logic [63:0]            rsp_tx_ff;
   logic [63:0]            rsp_rx_ff;

   logic                   skip;
   logic                   full;
   logic                   issue;
   logic [63:0]            cnt_ext;
   logic [63:0]            elapsed;
   logic                   do_export;
   logic [63:0]            ins_tx;
   logic [63:0]            ins_rx;
   logic [IDX_W-1:0]       fill_idx;
   logic [IDX_W-1:0]       wr_idx;
   logic                   wr_ins;

   // A negative receive count is ignored before the family is checked.
   assign skip     = !itm_tx_ff && itm_cnt_ff[31];
   assign full     = (fill_ff == CNT_W'(FLOW_ENTRIES));
   assign issue    = cmd.scan_en && (scan_idx_ff < fill_ff);
   assign cnt_ext  = {{32{itm_cnt_ff[31]}}, itm_cnt_ff};
   assign elapsed  = itm_now_ff - time_rd_ff;
   assign do_export = (elapsed >= export_interval);
   assign ins_tx   = itm_tx_ff ? cnt_ext : 64'd0;
   assign ins_rx   = itm_tx_ff ? 64'd0 : cnt_ext;
   assign fill_idx = fill_ff[IDX_W-1:0];
   assign wr_ins   = cmd.emit_miss && !full;
   assign wr_idx   = cmd.emit_miss ? fill_idx : hit_idx_ff;

   assign sts.drop      = skip || !itm_v4_ff;
   assign sts.hit       = cmp_vld_ff && (key_rd_ff == itm_key_ff);
   assign sts.scan_done = !cmp_vld_ff && (scan_idx_ff == fill_ff);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         itm_tx_ff  <= req_is_transmit;
         itm_v4_ff  <= req_is_ipv4;
         itm_key_ff <= req_key;
         itm_cnt_ff <= req_byte_count;
         itm_now_ff <= req_now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         if (wr_ins) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         if (cmd.load) begin
            scan_idx_ff <= '0;
            cmp_vld_ff  <= 1'b0;
         end else begin
            cmp_vld_ff <= issue;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_hit) begin
         hit_idx_ff <= scan_idx_ff[IDX_W-1:0] - IDX_W'(1);
      end
   end

   // Key memory: one read per cycle for the scan, written on insert.
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[scan_idx_ff[IDX_W-1:0]];
      if (wr_ins) begin
         key_mem[fill_idx] <= itm_key_ff;
      end
   end

   // Time and total memories: read at the matched entry.
   always_ff @(posedge clock) begin
      time_rd_ff <= time_mem[hit_idx_ff];
      tx_rd_ff   <= tx_mem[hit_idx_ff];
      rx_rd_ff   <= rx_mem[hit_idx_ff];
      if (wr_ins || (cmd.emit_hit && do_export)) begin
         time_mem[wr_idx] <= itm_now_ff;
      end
      if (wr_ins) begin
         tx_mem[wr_idx] <= ins_tx;
      end else if (cmd.emit_hit && itm_tx_ff) begin
         tx_mem[wr_idx] <= tx_rd_ff + cnt_ext;
      end
      if (wr_ins) begin
         rx_mem[wr_idx] <= ins_rx;
      end else if (cmd.emit_hit && !itm_tx_ff) begin
         rx_mem[wr_idx] <= rx_rd_ff + cnt_ext;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_drop || cmd.emit_hit || cmd.emit_miss) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_drop) begin
         rsp_status_ff <= skip ? tfbm_pkg::STATUS_OK : tfbm_pkg::STATUS_REJECT;
         rsp_export_ff <= 1'b0;
         rsp_key_ff    <= '0;
         rsp_tx_ff     <= '0;
         rsp_rx_ff     <= '0;
      end else if (cmd.emit_hit) begin
         rsp_status_ff <= tfbm_pkg::STATUS_OK;
         rsp_export_ff <= do_export;
         rsp_key_ff    <= do_export ? itm_key_ff : '0;
         rsp_tx_ff     <= do_export ? tx_rd_ff : 64'd0;
         rsp_rx_ff     <= do_export ? rx_rd_ff : 64'd0;
      end else if (cmd.emit_miss) begin
         rsp_status_ff <= full ? tfbm_pkg::STATUS_FULL : tfbm_pkg::STATUS_OK;
         rsp_export_ff <= 1'b1;
         rsp_key_ff    <= itm_key_ff;
         rsp_tx_ff     <= ins_tx;
         rsp_rx_ff     <= ins_rx;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_export_valid = rsp_export_ff;
   assign rsp_key          = rsp_key_ff;
   assign rsp_tx_total     = rsp_tx_ff;
   assign rsp_rx_total     = rsp_rx_ff;

endmodule

/* rtl/tcp_flow_byte_meter.sv */
// An ignored or rejected item is finished from the scan state. A known flow is
// scanned up to its matching entry, its entry is fetched and the export is
// evaluated. A new flow is scanned past every stored key and is then inserted
// if the table has room. Each finish waits for the result register to be free.
// A new item is accepted only once the last is finished; the scan compares one
// key per cycle. Reset clears the fill count, controller and result.
// ----------------------------------------------------------------------------
// tcp_flow_byte_meter
// Per-flow TCP byte meter: keeps transmit and receive totals per flow and
// reports a flow on insertion and whenever its export interval has passed.
// ----------------------------------------------------------------------------
module tcp_flow_byte_meter #(
   parameter int unsigned FLOW_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // Event input.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_is_transmit,
   input  logic                              req_is_ipv4,
   input  logic [31:0]                       req_proc_id,
   input  logic [31:0]                       req_src_addr,
   input  logic [15:0]                       req_src_port,
   input  logic [31:0]                       req_dst_addr,
   input  logic [15:0]                       req_dst_port,
   input  logic signed [31:0]                req_byte_count,
   input  logic [63:0]                       req_now_ns,
   // Result output.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_export_valid,
   output logic [31:0]                       rsp_rep_proc_id,
   output logic [31:0]                       rsp_rep_src_addr,
   output logic [15:0]                       rsp_rep_src_port,
   output logic [31:0]                       rsp_rep_dst_addr,
   output logic [15:0]                       rsp_rep_dst_port,
   output logic [63:0]                       rsp_rep_tx_total,
   output logic [63:0]                       rsp_rep_rx_total,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tfbm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [63:0]                       csr_pwdata,
   output logic [63:0]                       csr_prdata,
   output logic                              csr_pready
);

   tfbm_pkg::ctl_cmd_type  cmd;
   tfbm_pkg::ctl_sts_type  sts;
   tfbm_pkg::flow_key_type req_key;
   tfbm_pkg::flow_key_type rsp_key;
   logic [63:0]            interval_ff;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= tfbm_pkg::INTERVAL_RESET;
      end else if (csr_wr && (csr_paddr == tfbm_pkg::CSR_ADDR_INTERVAL)) begin
         interval_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr == tfbm_pkg::CSR_ADDR_INTERVAL) ? interval_ff : 64'd0;

   assign req_key.proc_id  = req_proc_id;
   assign req_key.src_addr = req_src_addr;
   assign req_key.src_port = req_src_port;
   assign req_key.dst_addr = req_dst_addr;
   assign req_key.dst_port = req_dst_port;

   assign rsp_rep_proc_id  = rsp_key.proc_id;
   assign rsp_rep_src_addr = rsp_key.src_addr;
   assign rsp_rep_src_port = rsp_key.src_port;
   assign rsp_rep_dst_addr = rsp_key.dst_addr;
   assign rsp_rep_dst_port = rsp_key.dst_port;

   tfbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfbm_datapath #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .export_interval  (interval_ff),
      .req_is_transmit  (req_is_transmit),
      .req_is_ipv4      (req_is_ipv4),
      .req_key          (req_key),
      .req_byte_count   (req_byte_count),
      .req_now_ns       (req_now_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_export_valid (rsp_export_valid),
      .rsp_key          (rsp_key),
      .rsp_tx_total     (rsp_rep_tx_total),
      .rsp_rx_total     (rsp_rep_rx_total)
   );

   // Only one item is in the block at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another was in progress");

   // A result without a report carries zero totals.
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_export_valid |-> rsp_rep_tx_total == 64'd0 &&
      rsp_rep_rx_total == 64'd0 && rsp_rep_proc_id == 32'd0)
      else $error("result without report has nonzero fields");

   // A rejected item never reports; a full-table miss always does.
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tfbm_pkg::STATUS_REJECT |-> !rsp_export_valid)
      else $error("rejected item carries a report");

   a_full_reports: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tfbm_pkg::STATUS_FULL |-> rsp_export_valid)
      else $error("table-full result carries no report");

endmodule

/* bench/tb_tcp_flow_byte_meter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_flow_byte_meter
// Self-checking bench for the TCP flow byte meter. A short table of directed
// events covers the edge cases. Random events follow under several export
// intervals, written over the configuration port. Every accepted event runs
// through a behavioural flow table in the bench. The expected report is
// queued and compared field by field with each accepted result. Both sides
// idle and stall at random, with two long receiver holds and two drain pauses.
// ----------------------------------------------------------------------------
module tb_tcp_flow_byte_meter;

   localparam int unsigned FLOW_ENTRIES = 64;
   localparam int          POOL_SIZE    = 66;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          NUM_DIRECTED = 20;

   typedef struct packed {
      logic                   is_transmit;
      logic                   is_ipv4;
      tfbm_pkg::flow_key_type key;
      logic [31:0]            byte_count;
      logic [63:0]            now_ns;
   } xfer_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   export_valid;
      tfbm_pkg::flow_key_type key;
      logic [63:0]            tx_total;
      logic [63:0]            rx_total;
   } report_type;

   // A row with typed set carries its own expected report.
   typedef struct packed {
      xfer_type   xfer;
      logic       typed;
      report_type report;
   } dir_row_type;

   localparam report_type             NO_REPORT = '0;
   localparam tfbm_pkg::flow_key_type KEY_ZERO  = '0;
   localparam tfbm_pkg::flow_key_type KEY_ONES  = '1;
   localparam tfbm_pkg::flow_key_type KEY_PID   = '{32'd1, 32'd0, 16'd0, 32'd0, 16'd0};
   localparam tfbm_pkg::flow_key_type KEY_SADDR = '{32'd0, 32'h8000_0000, 16'd0, 32'd0, 16'd0};
   localparam tfbm_pkg::flow_key_type KEY_SPORT = '{32'd0, 32'd0, 16'h8000, 32'd0, 16'd0};
   localparam tfbm_pkg::flow_key_type KEY_DADDR = '{32'd0, 32'd0, 16'd0, 32'd1, 16'd0};
   localparam tfbm_pkg::flow_key_type KEY_DPORT = '{32'd0, 32'd0, 16'd0, 32'd0, 16'd1};

   localparam dir_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{'{1'b1, 1'b1, KEY_ZERO, 32'd0, 64'd0}, 1'b1,
        '{tfbm_pkg::STATUS_OK, 1'b1, KEY_ZERO, 64'd0, 64'd0}},
      '{'{1'b0, 1'b1, KEY_ONES, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff}, 1'b1,
        '{tfbm_pkg::STATUS_OK, 1'b1, KEY_ONES, 64'd0, 64'h7fff_ffff}},
      // Negative receive counts are dropped before the IPv4 check.
      '{'{1'b0, 1'b0, KEY_ZERO, 32'h8000_0000, 64'd5}, 1'b1, NO_REPORT},
      '{'{1'b1, 1'b0, KEY_ZERO, 32'hffff_ffff, 64'd6}, 1'b1,
        '{tfbm_pkg::STATUS_REJECT, 1'b0, KEY_ZERO, 64'd0, 64'd0}},
      '{'{1'b0, 1'b1, KEY_ONES, 32'hffff_ffff, 64'd7}, 1'b1, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_ZERO, 32'd1000, 64'd10}, 1'b1, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_ZERO, 32'hffff_ffff, 64'd20}, 1'b0, NO_REPORT},
      '{'{1'b0, 1'b1, KEY_ZERO, 32'd50, 64'd999_999_999}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_ZERO, 32'd1, 64'd1_000_000_000}, 1'b0, NO_REPORT},
      // The elapsed time wraps round to one here.
      '{'{1'b1, 1'b1, KEY_ONES, 32'h8000_0000, 64'd0}, 1'b0, NO_REPORT},
      '{'{1'b0, 1'b1, KEY_ONES, 32'd0, 64'd999_999_999}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_PID, 32'd7, 64'd100}, 1'b0, NO_REPORT},
      '{'{1'b0, 1'b1, KEY_SADDR, 32'h7fff_ffff, 64'd101}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_SPORT, 32'hffff_fffe, 64'd102}, 1'b0, NO_REPORT},
      '{'{1'b0, 1'b1, KEY_DADDR, 32'd9, 64'd103}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_DPORT, 32'd3, 64'd104}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_PID, 32'h8000_0000, 64'd200}, 1'b0, NO_REPORT},
      '{'{1'b1, 1'b1, KEY_DPORT, 32'd3, 64'h8000_0000_0000_0000}, 1'b0, NO_REPORT},
      '{'{1'b0, 1'b0, KEY_SADDR, 32'd5, 64'd300}, 1'b1,
        '{tfbm_pkg::STATUS_REJECT, 1'b0, KEY_ZERO, 64'd0, 64'd0}},
      '{'{1'b1, 1'b1, KEY_SADDR, 32'd1, 64'hffff_ffff_ffff_ffff}, 1'b0, NO_REPORT}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_is_transmit;
   logic                  req_is_ipv4;
   logic [31:0]           req_proc_id;
   logic [31:0]           req_src_addr;
   logic [15:0]           req_src_port;
   logic [31:0]           req_dst_addr;
   logic [15:0]           req_dst_port;
   logic signed [31:0]    req_byte_count;
   logic [63:0]           req_now_ns;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_export_valid;
   logic [31:0]           rsp_rep_proc_id;
   logic [31:0]           rsp_rep_src_addr;
   logic [15:0]           rsp_rep_src_port;
   logic [31:0]           rsp_rep_dst_addr;
   logic [15:0]           rsp_rep_dst_port;
   logic [63:0]           rsp_rep_tx_total;
   logic [63:0]           rsp_rep_rx_total;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [tfbm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [63:0]           csr_pwdata;
   logic [63:0]           csr_prdata;
   logic                  csr_pready;

   // Flow table as the bench sees it.
   logic                  flow_used [FLOW_ENTRIES];
   tfbm_pkg::flow_key_type flow_key [FLOW_ENTRIES];
   logic [63:0]           flow_last [FLOW_ENTRIES];
   logic [63:0]           flow_tx [FLOW_ENTRIES];
   logic [63:0]           flow_rx [FLOW_ENTRIES];
   logic [63:0]           flow_interval;

   report_type            pending_reports [$];
   tfbm_pkg::flow_key_type key_pool [POOL_SIZE];
   logic [63:0]           sim_now;
   int                    mismatches = 0;
   int                    burst_left = 0;
   int                    hold_asked = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    stall_mode = 0;
   int                    stall_mode_left = 0;

   tcp_flow_byte_meter #(
      .FLOW_ENTRIES(FLOW_ENTRIES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_is_transmit  (req_is_transmit),
      .req_is_ipv4      (req_is_ipv4),
      .req_proc_id      (req_proc_id),
      .req_src_addr     (req_src_addr),
      .req_src_port     (req_src_port),
      .req_dst_addr     (req_dst_addr),
      .req_dst_port     (req_dst_port),
      .req_byte_count   (req_byte_count),
      .req_now_ns       (req_now_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_export_valid (rsp_export_valid),
      .rsp_rep_proc_id  (rsp_rep_proc_id),
      .rsp_rep_src_addr (rsp_rep_src_addr),
      .rsp_rep_src_port (rsp_rep_src_port),
      .rsp_rep_dst_addr (rsp_rep_dst_addr),
      .rsp_rep_dst_port (rsp_rep_dst_port),
      .rsp_rep_tx_total (rsp_rep_tx_total),
      .rsp_rep_rx_total (rsp_rep_rx_total),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic int find_flow(input tfbm_pkg::flow_key_type key);
      int i;
      for (i = 0; i < FLOW_ENTRIES; i++) begin
         if (flow_used[i] && flow_key[i] == key) return i;
      end
      return -1;
   endfunction

   // Works out the report for one accepted item and updates the flow table.
   function automatic report_type meter_step(input xfer_type xfer);
      report_type  rep;
      logic [63:0] amount;
      int          hit;
      int          vacant;
      int          i;
      rep = '0;
      vacant = -1;
      amount = {{32{xfer.byte_count[31]}}, xfer.byte_count};
      if (!xfer.is_transmit && xfer.byte_count[31]) return rep;
      if (!xfer.is_ipv4) begin
         rep.status = tfbm_pkg::STATUS_REJECT;
         return rep;
      end
      hit = find_flow(xfer.key);
      for (i = FLOW_ENTRIES - 1; i >= 0; i--) begin
         if (!flow_used[i]) vacant = i;
      end
      if (hit < 0) begin
         rep.export_valid = 1'b1;
         rep.key = xfer.key;
         if (xfer.is_transmit) rep.tx_total = amount;
         else rep.rx_total = amount;
         if (vacant < 0) begin
            rep.status = tfbm_pkg::STATUS_FULL;
         end else begin
            flow_used[vacant] = 1'b1;
            flow_key[vacant] = xfer.key;
            flow_last[vacant] = xfer.now_ns;
            flow_tx[vacant] = rep.tx_total;
            flow_rx[vacant] = rep.rx_total;
         end
         return rep;
      end
      if (xfer.now_ns - flow_last[hit] >= flow_interval) begin
         rep.export_valid = 1'b1;
         rep.key = xfer.key;
         rep.tx_total = flow_tx[hit];
         rep.rx_total = flow_rx[hit];
         flow_last[hit] = xfer.now_ns;
      end
      if (xfer.is_transmit) flow_tx[hit] = flow_tx[hit] + amount;
      else flow_rx[hit] = flow_rx[hit] + amount;
      return rep;
   endfunction

   function automatic tfbm_pkg::flow_key_type random_key();
      tfbm_pkg::flow_key_type key;
      key = {$urandom, $urandom, 16'($urandom), $urandom, 16'($urandom)};
      return key;
   endfunction

   // Mostly known flows with plausible times, some fresh flows and time jumps.
   function automatic xfer_type random_xfer(input logic [63:0] step_max);
      xfer_type xfer;
      int       slot;
      int       pick;
      xfer.is_transmit = 1'($urandom_range(0, 1));
      xfer.is_ipv4 = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 99) < 92) xfer.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else xfer.key = random_key();
      case ($urandom_range(0, 9))
         0: xfer.byte_count = $urandom;
         1: xfer.byte_count = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: xfer.byte_count = $urandom_range(0, 65535);
      endcase
      slot = find_flow(xfer.key);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         xfer.now_ns = {$urandom, $urandom};
      end else if (slot >= 0 && pick < 5) begin
         // Land on either side of the export boundary of this flow.
         case ($urandom_range(0, 2))
            0: xfer.now_ns = flow_last[slot] + flow_interval - 64'd1;
            1: xfer.now_ns = flow_last[slot] + flow_interval;
            default: xfer.now_ns = flow_last[slot] + flow_interval + 64'd1;
         endcase
      end else begin
         xfer.now_ns = sim_now + {$urandom, $urandom} % (step_max + 64'd1);
      end
      sim_now = xfer.now_ns;
      return xfer;
   endfunction

   task automatic send_xfer(input xfer_type xfer, input logic typed, input report_type typed_rep);
      report_type model_rep;
      req_valid <= 1'b1;
      req_is_transmit <= xfer.is_transmit;
      req_is_ipv4 <= xfer.is_ipv4;
      req_proc_id <= xfer.key.proc_id;
      req_src_addr <= xfer.key.src_addr;
      req_src_port <= xfer.key.src_port;
      req_dst_addr <= xfer.key.dst_addr;
      req_dst_port <= xfer.key.dst_port;
      req_byte_count <= xfer.byte_count;
      req_now_ns <= xfer.now_ns;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_rep = meter_step(xfer);
      pending_reports.push_back(typed ? typed_rep : model_rep);
   endtask

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= tfbm_pkg::CSR_ADDR_INTERVAL;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_interval(input logic [63:0] value);
      logic [63:0] readback;
      csr_access(1'b1, value, readback);
      flow_interval = value;
      csr_access(1'b0, 64'd0, readback);
      if (readback !== value)
         report_mismatch($sformatf("interval reads %h after writing %h", readback, value));
   endtask

   // Only items that reach the flow table count towards the target.
   task automatic run_random(input int target, input logic [63:0] step_max,
                             input logic with_hold, input logic with_pause);
      xfer_type xfer;
      int       counted;
      logic     mid_done;
      counted = 0;
      mid_done = 1'b0;
      while (counted < target) begin
         xfer = random_xfer(step_max);
         if (xfer.is_ipv4 && !(!xfer.is_transmit && xfer.byte_count[31])) counted++;
         send_xfer(xfer, 1'b0, NO_REPORT);
         if (!mid_done && counted >= target / 2) begin
            mid_done = 1'b1;
            if (with_hold) begin
               // Keep offering items while the receiver holds off.
               hold_asked <= hold_asked + 1;
               burst_left = 40;
            end
            if (with_pause) wait_drained();
         end
         pace_sender();
      end
   endtask

   task automatic check_report();
      report_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch($sformatf("result with no item outstanding, status %0d", rsp_status));
         return;
      end
      want = pending_reports.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, wanted %0d", rsp_status, want.status));
      if (rsp_export_valid !== want.export_valid)
         report_mismatch($sformatf("export_valid %0b, wanted %0b",
                                   rsp_export_valid, want.export_valid));
      if (rsp_rep_proc_id !== want.key.proc_id)
         report_mismatch($sformatf("proc_id %h, wanted %h", rsp_rep_proc_id, want.key.proc_id));
      if (rsp_rep_src_addr !== want.key.src_addr)
         report_mismatch($sformatf("src_addr %h, wanted %h",
                                   rsp_rep_src_addr, want.key.src_addr));
      if (rsp_rep_src_port !== want.key.src_port)
         report_mismatch($sformatf("src_port %h, wanted %h",
                                   rsp_rep_src_port, want.key.src_port));
      if (rsp_rep_dst_addr !== want.key.dst_addr)
         report_mismatch($sformatf("dst_addr %h, wanted %h",
                                   rsp_rep_dst_addr, want.key.dst_addr));
      if (rsp_rep_dst_port !== want.key.dst_port)
         report_mismatch($sformatf("dst_port %h, wanted %h",
                                   rsp_rep_dst_port, want.key.dst_port));
      if (rsp_rep_tx_total !== want.tx_total)
         report_mismatch($sformatf("tx_total %h, wanted %h", rsp_rep_tx_total, want.tx_total));
      if (rsp_rep_rx_total !== want.rx_total)
         report_mismatch($sformatf("rx_total %h, wanted %h", rsp_rep_rx_total, want.rx_total));
   endtask

   // Result side: check accepted items, then choose the stall for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_report();
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_mode_left <= $urandom_range(16, 200);
         end else begin
            stall_mode_left <= stall_mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin
      logic [63:0] readback;
      int          i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_is_transmit = 1'b0;
      req_is_ipv4 = 1'b0;
      req_proc_id = '0;
      req_src_addr = '0;
      req_src_port = '0;
      req_dst_addr = '0;
      req_dst_port = '0;
      req_byte_count = '0;
      req_now_ns = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sim_now = 64'd2_000_000_000;
      flow_interval = 64'd1_000_000_000;
      for (i = 0; i < FLOW_ENTRIES; i++) flow_used[i] = 1'b0;
      // Some pool keys differ from their neighbour in a single field only.
      for (i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = random_key();
         if (i % 3 == 1) begin
            key_pool[i] = key_pool[i - 1];
            case ($urandom_range(0, 4))
               0: key_pool[i].proc_id = $urandom;
               1: key_pool[i].src_addr = $urandom;
               2: key_pool[i].src_port = 16'($urandom);
               3: key_pool[i].dst_addr = $urandom;
               default: key_pool[i].dst_port = 16'($urandom);
            endcase
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b0, 64'd0, readback);
      if (readback !== 64'd1_000_000_000)
         report_mismatch($sformatf("interval after reset reads %h", readback));

      for (i = 0; i < NUM_DIRECTED; i++) begin
         send_xfer(DIRECTED_ROWS[i].xfer, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].report);
         pace_sender();
      end
      wait_drained();

      set_interval(64'd0);
      run_random(190, 64'd1000, 1'b1, 1'b0);
      wait_drained();
      set_interval(64'hffff_ffff_ffff_ffff);
      run_random(190, 64'd2_000_000, 1'b0, 1'b1);
      wait_drained();
      set_interval(64'($urandom_range(1, 5000)));
      run_random(230, 64'd3000, 1'b0, 1'b0);
      wait_drained();
      set_interval(64'd1_000_000_000);
      run_random(230, 64'd400_000_000, 1'b1, 1'b1);
      wait_drained();

      repeat (80) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS tcp_flow_byte_meter");
      end else begin
         $display("FAIL tcp_flow_byte_meter");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL tcp_flow_byte_meter");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tfbm_pkg.sv
rtl/tfbm_ctrl.sv
rtl/tfbm_datapath.sv
rtl/tcp_flow_byte_meter.sv
bench/tb_tcp_flow_byte_meter.sv
